// ----- src/mmp_pkg.sv -----
// Shared types, constants and hash function for the message mailbox pool.
package mmp_pkg;

  localparam int POOL_SIZE_DEF = 256;
  localparam int CHAIN_COUNT   = 16;
  localparam int CH_W          = 4;
  localparam int LINK_W        = 8;
  localparam int TALKER_W      = 24;
  localparam int STAMP_W       = 32;
  localparam int FUNC_W        = 3;
  localparam int CNT_W         = 8;
  localparam logic [CNT_W-1:0] MAX_PUNT = 8'd255;

  typedef enum logic [FUNC_W-1:0] {
    FN_GRAB = 3'd0,
    FN_FREE = 3'd1,
    FN_SEND = 3'd2,
    FN_GET  = 3'd3,
    FN_PUNT = 3'd4
  } func_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_GRAB_RD,
    S_SEND2,
    S_GET_START,
    S_WALK_RD,
    S_WALK_CHK,
    S_PUSH,
    S_FINISH
  } state_t;

  // (type*7 + id*3) & 0xf: only the low four bits of type and id matter
  function automatic logic [CH_W-1:0] chain_of(input logic [TALKER_W-1:0] t);
    logic [CH_W-1:0] ty;
    logic [CH_W-1:0] id;
    ty = t[16 +: CH_W];
    id = t[0 +: CH_W];
    return CH_W'({ty, 3'b000} - ty) + CH_W'({id, 1'b0} + id);
  endfunction

endpackage

// ----- src/mmp_if.sv -----
// Valid/ready channel interfaces for requests and results.
interface mmp_in_if;
  logic                          valid;
  logic                          ready;
  logic [mmp_pkg::FUNC_W-1:0]    func;
  logic [7:0]                    msg_index;
  logic [mmp_pkg::TALKER_W-1:0]  talker;
  logic [mmp_pkg::STAMP_W-1:0]   time_stamp;

  modport source (output valid, func, msg_index, talker, time_stamp, input ready);
  modport sink (input valid, func, msg_index, talker, time_stamp, output ready);
endinterface

interface mmp_out_if;
  logic                          valid;
  logic                          ready;
  logic                          status;
  logic [7:0]                    slot_out;
  logic [mmp_pkg::STAMP_W-1:0]   stamp_out;
  logic [mmp_pkg::CNT_W-1:0]     removed_count;

  modport source (output valid, status, slot_out, stamp_out, removed_count, input ready);
  modport sink (input valid, status, slot_out, stamp_out, removed_count, output ready);
endinterface

// ----- src/mmp_ram.sv -----
// Generic simple dual-port RAM with registered read.
module mmp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- src/message_mailbox_pool_unit.sv -----
// Message slot pool with free list, hashed mailbox chains and a get cursor.
//
// Requests arrive on in_if (func, msg_index, talker, time_stamp) and each
// produces exactly one result on out_if (status, slot_out, stamp_out,
// removed_count). A request transfers when valid and ready are both high.
// The unit works on one request at a time; in_if.ready is high only while
// it is idle. Grab reads the next free link in S_GRAB_RD, send clears the
// new tail's link in S_SEND2, and free goes straight to S_FINISH. Get walks
// its hash chain through the link/talker/stamp RAM read port, reading a slot
// in S_WALK_RD and checking it in S_WALK_CHK. Punt repeats that walk and
// frees each match in S_PUSH. The free-list head and the chain heads and
// tails are registers; the next links live in RAM, with a valid bit per entry
// standing in for the reset contents, so no clearing pass is needed after reset.
// Results sit in an output register; a finished result waits there while
// out_if.ready is low, and the next request may already be taken and
// worked on meanwhile, stalling only when its own result is due.
// Synchronous active-low reset empties all chains, clears the cursor and
// restores the full free list.
module message_mailbox_pool_unit #(
  parameter int POOL_SIZE = mmp_pkg::POOL_SIZE_DEF
) (
  input  logic clk,
  input  logic rst_n,
  mmp_in_if.sink    in_if,
  mmp_out_if.source out_if
);

  localparam int AW = $clog2(POOL_SIZE);
  localparam int SW = $clog2(POOL_SIZE + 1);
  localparam int LW = mmp_pkg::LINK_W;
  localparam int TW = mmp_pkg::TALKER_W;
  localparam int DW = mmp_pkg::STAMP_W;
  localparam int CW = mmp_pkg::CNT_W;

  mmp_pkg::state_t state_r, state_nxt;

  logic [LW-1:0] head_r [mmp_pkg::CHAIN_COUNT];
  logic [LW-1:0] tail_r [mmp_pkg::CHAIN_COUNT];
  logic          nl_vld_r [POOL_SIZE];

  logic [LW-1:0] free_head_r, free_head_nxt;
  logic          cur_vld_r, cur_vld_nxt;
  logic [TW-1:0] cur_tk_r, cur_tk_nxt;
  logic [LW-1:0] cur_cur_r, cur_cur_nxt;
  logic [LW-1:0] cur_prev_r, cur_prev_nxt;
  logic [SW-1:0] steps_r, steps_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          out_valid_r, out_valid_nxt;

  mmp_pkg::func_t func_r, func_nxt;
  logic [LW-1:0]  idx_r, idx_nxt;
  logic [TW-1:0]  tk_r, tk_nxt;
  logic [LW-1:0]  s_r, s_nxt;
  logic           res_status_r, res_status_nxt;
  logic [LW-1:0]  res_slot_r, res_slot_nxt;
  logic [DW-1:0]  res_stamp_r, res_stamp_nxt;
  logic [CW-1:0]  res_rem_r, res_rem_nxt;
  logic           o_status_r;
  logic [LW-1:0]  o_slot_r;
  logic [DW-1:0]  o_stamp_r;
  logic [CW-1:0]  o_rem_r;

  logic                  head_we, tail_we;
  logic [LW-1:0]         head_wd, tail_wd;
  logic [mmp_pkg::CH_W-1:0] ch;
  logic                  nl_we, tk_we;
  logic [AW-1:0]         nl_waddr, rd_addr, rd_addr_r;
  logic [LW-1:0]         nl_wdata, nl_q, link_q, rst_link;
  logic                  rd_vld_r;
  logic [TW-1:0]         tk_q;
  logic [DW-1:0]         st_q;
  logic                  accept, idx_ok, miss, out_free;

  assign accept   = in_if.valid && in_if.ready;
  assign in_if.ready = (state_r == mmp_pkg::S_IDLE);
  assign idx_ok   = (in_if.msg_index != '0) && (9'(in_if.msg_index) < 9'(POOL_SIZE));
  assign ch       = (state_r == mmp_pkg::S_IDLE) ? mmp_pkg::chain_of(in_if.talker)
                                                 : mmp_pkg::chain_of(tk_r);
  assign miss     = !cur_vld_r || (cur_tk_r != tk_r);
  assign out_free = !out_valid_r || out_if.ready;

  // Entries never written read as their reset link
  assign rst_link = (9'(rd_addr_r) < 9'(POOL_SIZE - 1)) ? LW'(rd_addr_r) + LW'(1) : '0;
  assign link_q   = rd_vld_r ? nl_q : rst_link;

  mmp_ram #(.WIDTH(LW), .DEPTH(POOL_SIZE)) u_link_ram (
    .clk(clk), .we(nl_we), .waddr(nl_waddr), .wdata(nl_wdata),
    .raddr(rd_addr), .rdata(nl_q)
  );
  mmp_ram #(.WIDTH(TW), .DEPTH(POOL_SIZE)) u_talker_ram (
    .clk(clk), .we(tk_we), .waddr(in_if.msg_index[AW-1:0]), .wdata(in_if.talker),
    .raddr(rd_addr), .rdata(tk_q)
  );
  mmp_ram #(.WIDTH(DW), .DEPTH(POOL_SIZE)) u_stamp_ram (
    .clk(clk), .we(tk_we), .waddr(in_if.msg_index[AW-1:0]), .wdata(in_if.time_stamp),
    .raddr(rd_addr), .rdata(st_q)
  );

  always_comb begin
    state_nxt      = state_r;
    free_head_nxt  = free_head_r;
    cur_vld_nxt    = cur_vld_r;
    cur_tk_nxt     = cur_tk_r;
    cur_cur_nxt    = cur_cur_r;
    cur_prev_nxt   = cur_prev_r;
    steps_nxt      = steps_r;
    cnt_nxt        = cnt_r;
    out_valid_nxt  = out_valid_r;
    func_nxt       = func_r;
    idx_nxt        = idx_r;
    tk_nxt         = tk_r;
    s_nxt          = s_r;
    res_status_nxt = res_status_r;
    res_slot_nxt   = res_slot_r;
    res_stamp_nxt  = res_stamp_r;
    res_rem_nxt    = res_rem_r;
    head_we  = 1'b0;
    head_wd  = '0;
    tail_we  = 1'b0;
    tail_wd  = '0;
    nl_we    = 1'b0;
    nl_waddr = '0;
    nl_wdata = '0;
    tk_we    = 1'b0;
    rd_addr  = cur_cur_r[AW-1:0];

    if (out_valid_r && out_if.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      mmp_pkg::S_IDLE: begin
        if (accept) begin
          func_nxt       = mmp_pkg::func_t'(in_if.func);
          idx_nxt        = in_if.msg_index;
          tk_nxt         = in_if.talker;
          res_status_nxt = 1'b0;
          res_slot_nxt   = '0;
          res_stamp_nxt  = '0;
          res_rem_nxt    = '0;
          cnt_nxt        = '0;
          state_nxt      = mmp_pkg::S_FINISH;
          unique case (mmp_pkg::func_t'(in_if.func))
            mmp_pkg::FN_GRAB: begin
              if (free_head_r == '0) begin
                res_status_nxt = 1'b1;
              end else begin
                rd_addr      = free_head_r[AW-1:0];
                res_slot_nxt = free_head_r;
                state_nxt    = mmp_pkg::S_GRAB_RD;
              end
            end
            mmp_pkg::FN_FREE: begin
              if (idx_ok) begin
                nl_we         = 1'b1;
                nl_waddr      = in_if.msg_index[AW-1:0];
                nl_wdata      = free_head_r;
                free_head_nxt = in_if.msg_index;
              end else begin
                res_status_nxt = 1'b1;
              end
            end
            mmp_pkg::FN_SEND: begin
              if (idx_ok) begin
                tk_we = 1'b1;
                if (in_if.talker == cur_tk_r) begin
                  cur_vld_nxt = 1'b0;
                end
                if (tail_r[ch] != '0) begin
                  nl_we    = 1'b1;
                  nl_waddr = tail_r[ch][AW-1:0];
                  nl_wdata = in_if.msg_index;
                end else begin
                  head_we = 1'b1;
                  head_wd = in_if.msg_index;
                end
                tail_we   = 1'b1;
                tail_wd   = in_if.msg_index;
                state_nxt = mmp_pkg::S_SEND2;
              end else begin
                res_status_nxt = 1'b1;
              end
            end
            mmp_pkg::FN_GET, mmp_pkg::FN_PUNT: begin
              state_nxt = mmp_pkg::S_GET_START;
            end
            default: begin
              res_status_nxt = 1'b1;
            end
          endcase
        end
      end
      mmp_pkg::S_GRAB_RD: begin
        free_head_nxt = link_q;
        state_nxt     = mmp_pkg::S_FINISH;
      end
      mmp_pkg::S_SEND2: begin
        nl_we     = 1'b1;
        nl_waddr  = idx_r[AW-1:0];
        nl_wdata  = '0;
        state_nxt = mmp_pkg::S_FINISH;
      end
      mmp_pkg::S_GET_START: begin
        if (miss) begin
          cur_vld_nxt  = 1'b1;
          cur_tk_nxt   = tk_r;
          cur_cur_nxt  = head_r[ch];
          cur_prev_nxt = '0;
        end
        steps_nxt = '0;
        state_nxt = mmp_pkg::S_WALK_RD;
      end
      mmp_pkg::S_WALK_RD: begin
        if (cur_cur_r == '0 || steps_r == SW'(POOL_SIZE)) begin
          if (func_r == mmp_pkg::FN_PUNT) begin
            res_rem_nxt = cnt_r;
          end else begin
            res_status_nxt = 1'b1;
          end
          state_nxt = mmp_pkg::S_FINISH;
        end else begin
          state_nxt = mmp_pkg::S_WALK_CHK;
        end
      end
      mmp_pkg::S_WALK_CHK: begin
        cur_cur_nxt = link_q;
        if (tk_q == cur_tk_r) begin
          // unlink the matching slot from its chain
          if (cur_prev_r != '0) begin
            nl_we    = 1'b1;
            nl_waddr = cur_prev_r[AW-1:0];
            nl_wdata = link_q;
            if (tail_r[ch] == cur_cur_r) begin
              tail_we = 1'b1;
              tail_wd = cur_prev_r;
            end
          end else begin
            head_we = 1'b1;
            head_wd = link_q;
            if (link_q == '0) begin
              tail_we = 1'b1;
              tail_wd = '0;
            end
          end
          if (func_r == mmp_pkg::FN_PUNT) begin
            s_nxt     = cur_cur_r;
            state_nxt = mmp_pkg::S_PUSH;
          end else begin
            res_slot_nxt  = cur_cur_r;
            res_stamp_nxt = st_q;
            state_nxt     = mmp_pkg::S_FINISH;
          end
        end else begin
          cur_prev_nxt = cur_cur_r;
          steps_nxt    = steps_r + SW'(1);
          state_nxt    = mmp_pkg::S_WALK_RD;
        end
      end
      mmp_pkg::S_PUSH: begin
        nl_we         = 1'b1;
        nl_waddr      = s_r[AW-1:0];
        nl_wdata      = free_head_r;
        free_head_nxt = s_r;
        cnt_nxt       = cnt_r + CW'(1);
        if (cnt_r + CW'(1) == mmp_pkg::MAX_PUNT) begin
          res_rem_nxt = mmp_pkg::MAX_PUNT;
          state_nxt   = mmp_pkg::S_FINISH;
        end else begin
          state_nxt = mmp_pkg::S_GET_START;
        end
      end
      mmp_pkg::S_FINISH: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          state_nxt     = mmp_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = mmp_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mmp_pkg::S_IDLE;
      free_head_r <= LW'(1);
      cur_vld_r   <= 1'b0;
      cur_tk_r    <= '0;
      cur_cur_r   <= '0;
      cur_prev_r  <= '0;
      steps_r     <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < mmp_pkg::CHAIN_COUNT; i++) begin
        head_r[i] <= '0;
        tail_r[i] <= '0;
      end
      for (int i = 0; i < POOL_SIZE; i++) begin
        nl_vld_r[i] <= 1'b0;
      end
    end else begin
      state_r     <= state_nxt;
      free_head_r <= free_head_nxt;
      cur_vld_r   <= cur_vld_nxt;
      cur_tk_r    <= cur_tk_nxt;
      cur_cur_r   <= cur_cur_nxt;
      cur_prev_r  <= cur_prev_nxt;
      steps_r     <= steps_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
      if (head_we) begin
        head_r[ch] <= head_wd;
      end
      if (tail_we) begin
        tail_r[ch] <= tail_wd;
      end
      if (nl_we) begin
        nl_vld_r[nl_waddr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    func_r       <= func_nxt;
    idx_r        <= idx_nxt;
    tk_r         <= tk_nxt;
    s_r          <= s_nxt;
    res_status_r <= res_status_nxt;
    res_slot_r   <= res_slot_nxt;
    res_stamp_r  <= res_stamp_nxt;
    res_rem_r    <= res_rem_nxt;
    rd_addr_r    <= rd_addr;
    rd_vld_r     <= nl_vld_r[rd_addr];
    if (state_r == mmp_pkg::S_FINISH && out_free) begin
      o_status_r <= res_status_r;
      o_slot_r   <= res_slot_r;
      o_stamp_r  <= res_stamp_r;
      o_rem_r    <= res_rem_r;
    end
  end

  assign out_if.valid         = out_valid_r;
  assign out_if.status        = o_status_r;
  assign out_if.slot_out      = o_slot_r;
  assign out_if.stamp_out     = o_stamp_r;
  assign out_if.removed_count = o_rem_r;

`ifndef SYNTH
  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> state_r != mmp_pkg::S_IDLE)
    else $error("request transfer did not start work");

  a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == mmp_pkg::S_WALK_RD |-> 9'(steps_r) <= 9'(POOL_SIZE))
    else $error("chain walk exceeded pool size");

  a_push_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == mmp_pkg::S_PUSH |-> s_r != '0)
    else $error("punt freeing slot zero");

  a_free_head_range: assert property (@(posedge clk) disable iff (!rst_n)
    9'(free_head_r) < 9'(POOL_SIZE))
    else $error("free list head out of range");

  a_result_on_finish: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == mmp_pkg::S_FINISH)
    else $error("result raised outside finish");
`endif

endmodule
